[sv/pac_pkg.sv]
// ----------------------------------------------------------------------------
// PMP access checker package
// Shared types, codes and helper functions for the protection entry chain.
// ----------------------------------------------------------------------------
package pac_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int SEL_W       = (IDX_W > 4) ? IDX_W : 4;

   // item modes
   localparam logic [2:0] MODE_LOAD      = 3'd0;
   localparam logic [2:0] MODE_STORE     = 3'd1;
   localparam logic [2:0] MODE_EXEC      = 3'd2;
   localparam logic [2:0] MODE_CSR_READ  = 3'd3;
   localparam logic [2:0] MODE_CSR_WRITE = 3'd4;

   // csr write kinds
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // address match modes
   localparam logic [1:0] AM_OFF   = 2'd0;
   localparam logic [1:0] AM_TOR   = 2'd1;
   localparam logic [1:0] AM_NA4   = 2'd2;
   localparam logic [1:0] AM_NAPOT = 2'd3;

   localparam logic [1:0] PRIV_MACHINE = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  csr_op;
      logic        csr_is_cfg;
      logic [3:0]  csr_number;
      logic [31:0] access_address;
      logic [1:0]  privilege;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic        allowed;
      logic        matched;
      logic [3:0]  match_index;
      logic [31:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic       lock;
      logic [1:0] am;
      logic       x;
      logic       w;
      logic       r;
   } cfg_type;

   // item state handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic [2:0]  mode;
      logic [1:0]  op;
      logic        is_cfg;
      logic [3:0]  num;
      logic [31:0] addr;
      logic [1:0]  priv;
      logic [31:0] wdata;
      logic [31:0] prev_word;
      logic        decided;
      logic        allowed;
      logic        any_active;
      logic [3:0]  index;
      logic [31:0] read_data;
   } flow_type;

   function automatic logic [7:0] pack_byte(input cfg_type c);
      pack_byte = {c.lock, 2'b00, c.am, c.x, c.w, c.r};
   endfunction

   function automatic cfg_type unpack_byte(input logic [7:0] v);
      unpack_byte = cfg_type'({v[7], v[4:0]});
   endfunction

   function automatic logic [31:0] apply_op(input logic [31:0] old_value,
                                             input logic [1:0]  op,
                                             input logic [31:0] operand);
      unique case (op)
         OP_WRITE: apply_op = operand;
         OP_SET:   apply_op = old_value | operand;
         OP_CLEAR: apply_op = old_value & ~operand;
         default:  apply_op = old_value;
      endcase
   endfunction

endpackage

[sv/pac_cell.sv]
// ----------------------------------------------------------------------------
// PMP entry cell
// Holds one address word and one entry config, updates them on csr items,
// tests check items against its region and hands the item to the next cell.
// ----------------------------------------------------------------------------
module pac_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [pac_pkg::IDX_W-1:0] cell_index,
   input  pac_pkg::flow_type         up_flow,
   output pac_pkg::flow_type         down_flow
);
   import pac_pkg::*;

   logic [31:0] raw_ff, raw_in;
   cfg_type     cfg_ff, cfg_in;
   flow_type    stage_ff, stage_in;

   logic        is_check, is_csr, is_wr, addr_hit, cfg_hit;
   logic [1:0]  lane;
   logic [31:0] raw_sh, prev_sh, ones, napot_mask, op_result;
   logic [7:0]  lane_byte;
   logic        tor_hit, na4_hit, napot_hit, active, hit, perm, bypass;

   always_comb begin
      is_check = up_flow.valid && (up_flow.mode == MODE_LOAD ||
                 up_flow.mode == MODE_STORE || up_flow.mode == MODE_EXEC);
      is_csr   = up_flow.valid && (up_flow.mode == MODE_CSR_READ ||
                 up_flow.mode == MODE_CSR_WRITE);
      is_wr    = up_flow.mode == MODE_CSR_WRITE;
      addr_hit = is_csr && !up_flow.is_cfg &&
                 (SEL_W'(up_flow.num) == SEL_W'(cell_index));
      cfg_hit  = is_csr && up_flow.is_cfg &&
                 (SEL_W'(up_flow.num) == SEL_W'(cell_index >> 2));
      lane     = cell_index[1:0];

      // region tests: TOR range, NA4 word, NAPOT masked compare
      raw_sh     = {raw_ff[29:0], 2'b00};
      prev_sh    = {up_flow.prev_word[29:0], 2'b00};
      tor_hit    = (up_flow.addr >= prev_sh) && (up_flow.addr < raw_sh);
      na4_hit    = up_flow.addr[31:2] == raw_ff[29:0];
      ones       = raw_ff ^ (raw_ff + 32'd1);
      napot_mask = {ones[29:0], 2'b11};
      napot_hit  = ((up_flow.addr ^ raw_sh) & ~napot_mask) == 32'd0;
      active     = cfg_ff.am != AM_OFF;
      unique case (cfg_ff.am)
         AM_TOR:   hit = tor_hit;
         AM_NA4:   hit = na4_hit;
         AM_NAPOT: hit = napot_hit;
         default:  hit = 1'b0;
      endcase

      // permission of this entry
      unique case (up_flow.mode)
         MODE_LOAD:  perm = cfg_ff.r;
         MODE_STORE: perm = cfg_ff.w;
         default:    perm = cfg_ff.x && cfg_ff.r;
      endcase
      bypass = !cfg_ff.lock && up_flow.priv[1];

      // csr update of the address word or of this entry's config byte
      raw_in = raw_ff;
      cfg_in = cfg_ff;
      if (addr_hit && is_wr) begin
         raw_in = apply_op(raw_ff, up_flow.op, up_flow.wdata);
      end
      lane_byte = up_flow.wdata[8*lane +: 8];
      op_result = apply_op({24'd0, pack_byte(cfg_ff)}, up_flow.op, {24'd0, lane_byte});
      if (cfg_hit && is_wr && !cfg_ff.lock) begin
         cfg_in = unpack_byte(op_result[7:0]);
      end

      // hand the item on
      stage_in           = up_flow;
      stage_in.prev_word = raw_ff;
      if (addr_hit) begin
         stage_in.read_data = raw_in;
      end
      if (cfg_hit) begin
         stage_in.read_data[8*lane +: 8] = pack_byte(cfg_in);
      end
      if (is_check && !up_flow.decided && active) begin
         stage_in.any_active = 1'b1;
         if (hit) begin
            stage_in.decided = 1'b1;
            stage_in.allowed = perm || bypass;
            stage_in.index   = 4'(cell_index);
         end
      end
   end

   // hold entry state, advance the item
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff         <= '0;
         cfg_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         raw_ff   <= raw_in;
         cfg_ff   <= cfg_in;
         stage_ff <= stage_in;
      end
   end

   assign down_flow = stage_ff;

endmodule

[sv/pmp_access_checker_top.sv]
// ----------------------------------------------------------------------------
// PMP access checker
// Sixteen protection entries as a chain of cells; every item walks the chain.
// ----------------------------------------------------------------------------
// Each item is registered in every cell of the chain in turn, from acceptance to result.
// Throughput: one item per cycle; the whole chain halts while a result is
// stalled at the output.
// Reset: clears all address words and configs (every entry off) and empties
// the chain.
module pmp_access_checker_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pac_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pac_pkg::rsp_type rsp_data
);
   import pac_pkg::*;

   flow_type links [0:NUM_ENTRIES];
   flow_type last;
   logic     advance, last_check, last_csr;

   // move the chain whenever the output slot is free or being taken
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // load a new item into the head of the chain
   always_comb begin
      links[0]            = '0;
      links[0].valid      = req_valid;
      links[0].mode       = req_data.mode;
      links[0].op         = req_data.csr_op;
      links[0].is_cfg     = req_data.csr_is_cfg;
      links[0].num        = req_data.csr_number;
      links[0].addr       = req_data.access_address;
      links[0].priv       = req_data.privilege;
      links[0].wdata      = req_data.write_data;
   end

   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      pac_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(i)),
         .up_flow    (links[i]),
         .down_flow  (links[i+1])
      );
   end

   assign last       = links[NUM_ENTRIES];
   assign rsp_valid  = last.valid;
   assign last_check = last.mode == MODE_LOAD || last.mode == MODE_STORE ||
                       last.mode == MODE_EXEC;
   assign last_csr   = last.mode == MODE_CSR_READ || last.mode == MODE_CSR_WRITE;

   // finish the item: matched result, default rule when no entry matched, or csr read data
   always_comb begin
      rsp_data = '{allowed: 1'b1, matched: 1'b0, match_index: 4'd0, read_data: 32'd0};
      if (last_check) begin
         if (last.decided) begin
            rsp_data.allowed     = last.allowed;
            rsp_data.matched     = 1'b1;
            rsp_data.match_index = last.index;
         end else begin
            rsp_data.allowed = (last.priv == PRIV_MACHINE) || !last.any_active;
         end
      end else if (last_csr) begin
         rsp_data.read_data = last.read_data;
      end
   end

   a_csr_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_csr |-> rsp_data.allowed && !rsp_data.matched)
      else $error("csr item gave a denied or matched result");

   a_no_match_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.matched |-> rsp_data.match_index == 4'd0)
      else $error("match index set without a match");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_check_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_check |-> last.read_data == 32'd0)
      else $error("check item picked up csr read data");

endmodule
